@@ sv/spl_pkg.sv @@
// shared types and constants for the sorted priority list
// no dependencies
`default_nettype none

package spl_pkg;

    localparam int DEPTH   = 64;
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int KEY_W   = 32;
    localparam int ID_W    = 16;
    localparam int REQ_W   = 2;
    localparam int STAT_W  = 2;
    localparam int COUNT_W = 7;

    localparam logic [REQ_W-1:0] REQ_INSERT = 2'd0;
    localparam logic [REQ_W-1:0] REQ_POP    = 2'd1;
    localparam logic [REQ_W-1:0] REQ_FIND   = 2'd2;
    localparam logic [REQ_W-1:0] REQ_REMOVE = 2'd3;

    localparam logic [STAT_W-1:0] ST_OK       = 2'd0;
    localparam logic [STAT_W-1:0] ST_EMPTY    = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL     = 2'd2;
    localparam logic [STAT_W-1:0] ST_NOTFOUND = 2'd3;

    typedef struct packed {
        logic             valid;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  ident;
    } t_entry;

    // broadcast to every cell for the request being executed
    typedef struct packed {
        logic             do_ins;
        logic             do_pop;
        logic             do_rm;
        logic [KEY_W-1:0] key;
        logic [ID_W-1:0]  ident;
    } t_cell_ctl;

endpackage

`default_nettype wire

@@ sv/spl_if.sv @@
// request and response channel interfaces of the sorted priority list
// depends on spl_pkg
`default_nettype none

interface spl_req_if;
    import spl_pkg::*;
    logic             valid;
    logic             ready;
    logic [REQ_W-1:0] req_type;
    logic [KEY_W-1:0] key;
    logic [ID_W-1:0]  ident;
    modport source (output valid, req_type, key, ident, input ready);
    modport sink (input valid, req_type, key, ident, output ready);
endinterface

interface spl_rsp_if;
    import spl_pkg::*;
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic               found;
    logic [KEY_W-1:0]   match_key;
    logic [ID_W-1:0]    match_ident;
    logic [KEY_W-1:0]   head_key;
    logic [ID_W-1:0]    head_ident;
    logic [COUNT_W-1:0] entry_count;
    modport source (output valid, status, found, match_key, match_ident,
                    head_key, head_ident, entry_count, input ready);
    modport sink (input valid, status, found, match_key, match_ident,
                  head_key, head_ident, entry_count, output ready);
endinterface

`default_nettype wire

@@ sv/sorted_priority_list_core.sv @@
// top level of the sorted priority list: row of list cells plus response register
// depends on spl_pkg, spl_if, spl_cell
// response: registered; it becomes valid at the edge that accepts the request
// throughput: one request per cycle while every response is taken as soon as it is valid
// a held response blocks the input; a new request enters in the cycle the held one leaves
// reset: synchronous, active low; clears every slot valid bit, the count and the response valid flag
`default_nettype none

module sorted_priority_list_core (
    input  wire         i_clk,
    input  wire         i_rst_n,
    spl_req_if.sink     i_req,
    spl_rsp_if.source   o_rsp
);
    import spl_pkg::*;

    // cell row wiring
    t_entry    cell_q [DEPTH];
    t_entry    cell_left [DEPTH];
    t_entry    cell_right [DEPTH];
    logic      cell_past [DEPTH];
    logic      cell_left_past [DEPTH];
    logic      cell_hit [DEPTH];
    logic      cell_hit_in [DEPTH];
    logic      cell_first [DEPTH];
    t_cell_ctl ctl;

    logic [CNT_W-1:0] r_count;
    logic [CNT_W-1:0] n_count;

    // response register
    logic               r_rsp_valid;
    logic [STAT_W-1:0]  r_status;
    logic               r_found;
    logic [KEY_W-1:0]   r_match_key;
    logic [ID_W-1:0]    r_match_ident;
    logic [KEY_W-1:0]   r_head_key;
    logic [ID_W-1:0]    r_head_ident;
    logic [COUNT_W-1:0] r_entry_count;

    logic               n_status_ok;
    logic [STAT_W-1:0]  n_status;
    logic               n_found;
    logic [KEY_W-1:0]   n_match_key;
    logic [ID_W-1:0]    n_match_ident;
    t_entry             n_head;
    t_entry             sel_match;
    logic [CNT_W+COUNT_W-1:0] count_wide;

    logic accept;
    logic full;
    logic empty;
    logic any_hit;

    assign i_req.ready = !r_rsp_valid || o_rsp.ready;
    assign accept      = i_req.valid && i_req.ready;
    assign full        = (r_count == CNT_W'(DEPTH));
    assign empty       = (r_count == '0);
    assign any_hit     = cell_hit[DEPTH-1];

    // broadcast controls; a request not accepted leaves every cell unchanged
    always_comb begin
        ctl.do_ins = accept && (i_req.req_type == REQ_INSERT) && !full;
        ctl.do_pop = accept && (i_req.req_type == REQ_POP) && !empty;
        ctl.do_rm  = accept && (i_req.req_type == REQ_REMOVE);
        ctl.key    = i_req.key;
        ctl.ident  = i_req.ident;
    end

    // neighbor links: insert shifts toward the tail, pop and remove toward the head
    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            if (g == 0) begin : g_head
                assign cell_left[g]      = '0;
                assign cell_left_past[g] = 1'b0;
                assign cell_hit_in[g]    = 1'b0;
            end else begin : g_body
                assign cell_left[g]      = cell_q[g-1];
                assign cell_left_past[g] = cell_past[g-1];
                assign cell_hit_in[g]    = cell_hit[g-1];
            end
            if (g == DEPTH - 1) begin : g_tail
                assign cell_right[g] = '0;
            end else begin : g_mid
                assign cell_right[g] = cell_q[g+1];
            end

            spl_cell u_cell (
                .i_clk       (i_clk),
                .i_rst_n     (i_rst_n),
                .i_ctl       (ctl),
                .i_left      (cell_left[g]),
                .i_right     (cell_right[g]),
                .i_left_past (cell_left_past[g]),
                .i_hit_in    (cell_hit_in[g]),
                .o_entry     (cell_q[g]),
                .o_past      (cell_past[g]),
                .o_hit       (cell_hit[g]),
                .o_first     (cell_first[g])
            );
        end
    endgenerate

    // first matching slot is one-hot, so an or over the row selects it
    always_comb begin
        sel_match = '0;
        for (int i = 0; i < DEPTH; i++) begin
            if (cell_first[i]) begin
                sel_match = sel_match | cell_q[i];
            end
        end
    end

    // result fields and the head after the request
    always_comb begin
        n_status_ok   = 1'b1;
        n_status      = ST_OK;
        n_found       = 1'b0;
        n_match_key   = '0;
        n_match_ident = '0;
        n_count       = r_count;
        n_head        = cell_q[0];
        case (i_req.req_type)
            REQ_INSERT: begin
                if (full) begin
                    n_status = ST_FULL;
                end else begin
                    n_count = r_count + CNT_W'(1);
                    // new entry lands at the head when the head slot is empty or its key is not below it
                    if (cell_past[0]) begin
                        n_head = '{valid: 1'b1, key: i_req.key, ident: i_req.ident};
                    end
                end
            end
            REQ_POP: begin
                if (empty) begin
                    n_status = ST_EMPTY;
                end else begin
                    n_match_key   = cell_q[0].key;
                    n_match_ident = cell_q[0].ident;
                    n_count       = r_count - CNT_W'(1);
                    n_head        = cell_q[1];
                end
            end
            REQ_FIND, REQ_REMOVE: begin
                if (any_hit) begin
                    n_found       = 1'b1;
                    n_match_key   = sel_match.key;
                    n_match_ident = sel_match.ident;
                    if (i_req.req_type == REQ_REMOVE) begin
                        n_count = r_count - CNT_W'(1);
                        if (cell_first[0]) begin
                            n_head = cell_q[1];
                        end
                    end
                end else begin
                    n_status_ok = 1'b0;
                    n_status    = ST_NOTFOUND;
                end
            end
            default: begin
                n_status_ok = 1'b1;
            end
        endcase
    end

    // the count field carries the low bits of the stored count
    assign count_wide = {{COUNT_W{1'b0}}, n_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_rsp_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_count     <= n_count;
                r_rsp_valid <= 1'b1;
            end else if (o_rsp.ready) begin
                r_rsp_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_status      <= n_status_ok ? n_status : ST_NOTFOUND;
            r_found       <= n_found;
            r_match_key   <= n_match_key;
            r_match_ident <= n_match_ident;
            r_head_key    <= n_head.valid ? n_head.key : '0;
            r_head_ident  <= n_head.valid ? n_head.ident : '0;
            r_entry_count <= count_wide[COUNT_W-1:0];
        end
    end

    assign o_rsp.valid       = r_rsp_valid;
    assign o_rsp.status      = r_status;
    assign o_rsp.found       = r_found;
    assign o_rsp.match_key   = r_match_key;
    assign o_rsp.match_ident = r_match_ident;
    assign o_rsp.head_key    = r_head_key;
    assign o_rsp.head_ident  = r_head_ident;
    assign o_rsp.entry_count = r_entry_count;

endmodule

`default_nettype wire

@@ sv/spl_cell.sv @@
// one slot of the sorted list: holds an entry, shifts with its neighbors
// depends on spl_pkg
`default_nettype none

module spl_cell (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire spl_pkg::t_cell_ctl i_ctl,
    input  wire spl_pkg::t_entry    i_left,
    input  wire spl_pkg::t_entry    i_right,
    input  wire                 i_left_past,
    input  wire                 i_hit_in,
    output spl_pkg::t_entry     o_entry,
    output logic                o_past,
    output logic                o_hit,
    output logic                o_first
);
    import spl_pkg::*;

    logic r_valid;
    logic n_valid;
    logic [KEY_W-1:0] r_key;
    logic [KEY_W-1:0] n_key;
    logic [ID_W-1:0] r_ident;
    logic [ID_W-1:0] n_ident;
    logic match;

    // at or beyond the insert point: empty slot or key not below the new one
    assign o_past  = !r_valid || (r_key >= i_ctl.key);
    assign match   = r_valid && (r_ident == i_ctl.ident);
    assign o_hit   = i_hit_in || match;
    assign o_first = match && !i_hit_in;
    assign o_entry = '{valid: r_valid, key: r_key, ident: r_ident};

    always_comb begin
        n_valid = r_valid;
        n_key   = r_key;
        n_ident = r_ident;
        if (i_ctl.do_ins && o_past) begin
            if (i_left_past) begin
                n_valid = i_left.valid;
                n_key   = i_left.key;
                n_ident = i_left.ident;
            end else begin
                n_valid = 1'b1;
                n_key   = i_ctl.key;
                n_ident = i_ctl.ident;
            end
        end else if (i_ctl.do_pop || (i_ctl.do_rm && o_hit)) begin
            n_valid = i_right.valid;
            n_key   = i_right.key;
            n_ident = i_right.ident;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_key   <= n_key;
        r_ident <= n_ident;
    end

endmodule

`default_nettype wire
